>>> sv/bla_pkg.sv
// bla_pkg: shared constants, types and tables of the luma-to-glyph converter
// register indexes, gamma table (built at elaboration), glyph ramp lookup
// used by block_luma_to_ascii_glyph_core; no dependencies
package bla_pkg;

	localparam int SUM_W     = 24;
	localparam int RAMP_LEN  = 7;
	localparam int BLK_STEPS = 24;
	localparam int POS_STEPS = 12;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd1;
	localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd2;
	localparam logic [2:0] REG_CELLS_ACROSS = 3'd3;
	localparam logic [2:0] REG_CELLS_DOWN   = 3'd4;
	localparam logic [2:0] REG_INVERT_RAMP  = 3'd5;

	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [7:0]  RST_BLOCK_WIDTH  = 8'd8;
	localparam logic [7:0]  RST_BLOCK_HEIGHT = 8'd16;
	localparam logic [8:0]  RST_CELLS_ACROSS = 9'd80;
	localparam logic [8:0]  RST_CELLS_DOWN   = 9'd30;
	localparam logic        RST_INVERT_RAMP  = 1'b1;

	typedef logic [7:0] gamma_tab_t [256];
	typedef logic [6:0] ramp_tab_t [RAMP_LEN];

	// "@#*+=- "
	localparam ramp_tab_t RAMP_CHARS = '{7'd64, 7'd35, 7'd42, 7'd43, 7'd61, 7'd45, 7'd32};

	// entry v = round(255*(v/255)^(1/2.2)), exact: count k with (2k-1)^11 <= 2048*255^6*v^5
	function automatic gamma_tab_t build_gamma();
		gamma_tab_t   tab;
		logic [127:0] rhs;
		logic [127:0] lhs;
		int           g;
		int           v;
		int           i;
		bit           stop;
		g = 0;
		for (v = 0; v < 256; v++) begin
			rhs = 128'd2048;
			for (i = 0; i < 6; i++) rhs = rhs * 128'd255;
			for (i = 0; i < 5; i++) rhs = rhs * 128'(v);
			stop = 1'b0;
			while (g < 255 && !stop) begin
				lhs = 128'd1;
				for (i = 0; i < 11; i++) lhs = lhs * 128'(2 * g + 1);
				if (lhs > rhs) stop = 1'b1;
				else g++;
			end
			tab[v] = 8'(g);
		end
		return tab;
	endfunction

	localparam gamma_tab_t GAMMA_TABLE = build_gamma();

	// index = min(floor(RAMP_LEN*v/255), RAMP_LEN-1), found by threshold compares
	function automatic logic [6:0] ramp_glyph(input logic [7:0] v);
		logic [2:0] idx;
		int         k;
		idx = '0;
		for (k = 1; k < RAMP_LEN; k++) begin
			if (11'(RAMP_LEN) * {3'b0, v} >= 11'(255 * k)) idx = idx + 3'd1;
		end
		return RAMP_CHARS[idx];
	endfunction

endpackage

>>> sv/block_luma_to_ascii_glyph_core.sv
// block_luma_to_ascii_glyph_core: top level of the luma-to-glyph converter
// depends on bla_pkg and bla_ram (per-column block sums)
//
// Pixels (8-bit luma, tuser = frame start) stream in raster order and are summed
// per cell column in a ram of MAX_CELLS_ACROSS x 24 bits, read at accept and written
// back the next cycle, with forwarding when back-to-back pixels hit the same column.
// A pixel that does not close a block keeps s_tready up. A pixel that closes a block
// holds s_tready low until its glyph is loaded: the block average runs through a
// shared restoring divider at one quotient bit per cycle (24 steps), then the gamma
// lookup and the glyph ramp are each registered. Writing block_width re-derives the
// column position with the same divider, 12 steps, input held off. Each result beat
// carries glyph, cell column and cell row; tlast marks the frame's last cell. Column
// sums are cleared at frame start through per-column valid bits.
module block_luma_to_ascii_glyph_core #(
	parameter int MAX_CELLS_ACROSS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] luma
	input  logic [0:0]  s_tuser,   // [0] frame_start
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] glyph, [14:7] cell_column, [22:15] cell_row
	output logic        m_tlast,   // frame_done
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_wdata
);

	localparam int COL_W = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
	localparam logic [11:0] MAX_CA = 12'(MAX_CELLS_ACROSS);

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_GAM    = 3'd2;
	localparam logic [2:0] ST_OUT    = 3'd3;
	localparam logic [2:0] ST_RECALC = 3'd4;

	localparam int SW = bla_pkg::SUM_W;

	// configuration registers
	logic [11:0] fw_q;
	logic [7:0]  bw_q;
	logic [7:0]  bh_q;
	logic [8:0]  ca_q;
	logic [8:0]  cd_q;
	logic        inv_q;

	logic [11:0] fw_e;
	logic [7:0]  bw_e;
	logic [7:0]  bh_e;
	logic [11:0] ca_raw;
	logic [11:0] ca_e;
	logic [8:0]  cd_e;

	// position state
	logic [11:0] px_q;
	logic [7:0]  xin_q;
	logic [11:0] col_q;
	logic [7:0]  line_q;
	logic [7:0]  crow_q;
	logic        fover_q;

	logic [2:0] state_q;

	// accept-side signals
	logic        in_acc;
	logic        fs;
	logic        bw_write;
	logic [11:0] px_c;
	logic [7:0]  xin_c;
	logic [11:0] col_c;
	logic [7:0]  line_c;
	logic [7:0]  crow_c;
	logic        fover_c;
	logic        active;
	logic        first_c;
	logic        close_c;
	logic        fdone_c;
	logic        fwd_c;
	logic        vld_c;
	logic [12:0] px_inc;
	logic [8:0]  xin_inc;
	logic [8:0]  line_inc;
	logic [8:0]  crow_inc;
	logic        wrap;
	logic        xwrap;
	logic        lwrap;
	logic        cwrap;

	// stage 1: ram data back, sum updated and written
	logic          v_s1;
	logic [11:0]   col_s1;
	logic [7:0]    crow_s1;
	logic          first_s1;
	logic          close_s1;
	logic          fdone_s1;
	logic [7:0]    luma_s1;
	logic          fwd_s1;
	logic          vld_s1;
	logic [SW-1:0] fwd_sum_s1;
	logic [SW-1:0] ram_rdata;
	logic [SW-1:0] old_sum;
	logic [SW-1:0] new_sum;

	logic [MAX_CELLS_ACROSS-1:0] vbits_q;

	// shared divider
	logic [SW-1:0] div_quo_q;
	logic [15:0]   div_rem_q;
	logic [15:0]   div_d_q;
	logic [4:0]    div_cnt_q;
	logic [16:0]   rem2;
	logic          ge;
	logic [15:0]   rem_next;
	logic [7:0]    avg;

	// block result being finished
	logic [7:0] col_d_q;
	logic [7:0] crow_d_q;
	logic       fdone_d_q;
	logic [7:0] gam_q;

	// output register
	logic       m_tvalid_q;
	logic [6:0] glyph_q;
	logic [7:0] ocol_q;
	logic [7:0] orow_q;
	logic       olast_q;
	logic       out_load;

	assign fw_e   = (fw_q == 12'd0) ? 12'd1 : fw_q;
	assign bw_e   = (bw_q == 8'd0) ? 8'd1 : bw_q;
	assign bh_e   = (bh_q == 8'd0) ? 8'd1 : bh_q;
	assign ca_raw = (ca_q == 9'd0) ? 12'd1 : {3'b0, ca_q};
	assign ca_e   = (ca_raw > MAX_CA) ? MAX_CA : ca_raw;
	assign cd_e   = (cd_q == 9'd0) ? 9'd1 : ((cd_q > 9'd256) ? 9'd256 : cd_q);

	assign bw_write = cfg_we && (cfg_index == bla_pkg::REG_BLOCK_WIDTH);
	assign s_tready = (state_q == ST_RUN) && !(v_s1 && close_s1) && !bw_write;
	assign in_acc   = s_tvalid && s_tready;
	assign fs       = s_tuser[0];

	always_comb begin
		px_c    = fs ? 12'd0 : px_q;
		xin_c   = fs ? 8'd0 : xin_q;
		col_c   = fs ? 12'd0 : col_q;
		line_c  = fs ? 8'd0 : line_q;
		crow_c  = fs ? 8'd0 : crow_q;
		fover_c = fs ? 1'b0 : fover_q;

		active  = !fover_c && (col_c < ca_e) && (line_c < bh_e);
		first_c = (line_c == 8'd0) && (xin_c == 8'd0);
		close_c = (line_c == bh_e - 8'd1) && (xin_c == bw_e - 8'd1);
		fdone_c = (col_c == ca_e - 12'd1) && ({1'b0, crow_c} == cd_e - 9'd1);

		// same column still being written back: take its sum directly
		fwd_c = v_s1 && (col_s1 == col_c) && !fs;
		vld_c = !fs && vbits_q[col_c[COL_W-1:0]];

		px_inc   = {1'b0, px_c} + 13'd1;
		xin_inc  = {1'b0, xin_c} + 9'd1;
		line_inc = {1'b0, line_c} + 9'd1;
		crow_inc = {1'b0, crow_c} + 9'd1;
		wrap     = px_inc >= {1'b0, fw_e};
		xwrap    = xin_inc >= {1'b0, bw_e};
		lwrap    = line_inc >= {1'b0, bh_e};
		cwrap    = crow_inc >= cd_e;
	end

	always_comb begin
		old_sum = fwd_s1 ? fwd_sum_s1 : (vld_s1 ? ram_rdata : '0);
		new_sum = first_s1 ? {16'b0, luma_s1} : old_sum + {16'b0, luma_s1};
	end

	bla_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_CELLS_ACROSS)
	) u_sums (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1[COL_W-1:0]),
		.wdata(new_sum),
		.raddr(col_c[COL_W-1:0]),
		.rdata(ram_rdata)
	);

	// divider step, one quotient bit per cycle
	always_comb begin
		rem2     = {div_rem_q, div_quo_q[SW-1]};
		ge       = rem2 >= {1'b0, div_d_q};
		rem_next = ge ? 16'(rem2 - {1'b0, div_d_q}) : rem2[15:0];
		avg      = (|div_quo_q[SW-1:8]) ? 8'hFF : div_quo_q[7:0];
	end

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= bla_pkg::RST_FRAME_WIDTH;
			bw_q  <= bla_pkg::RST_BLOCK_WIDTH;
			bh_q  <= bla_pkg::RST_BLOCK_HEIGHT;
			ca_q  <= bla_pkg::RST_CELLS_ACROSS;
			cd_q  <= bla_pkg::RST_CELLS_DOWN;
			inv_q <= bla_pkg::RST_INVERT_RAMP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bla_pkg::REG_FRAME_WIDTH:  fw_q  <= cfg_wdata;
				bla_pkg::REG_BLOCK_WIDTH:  bw_q  <= cfg_wdata[7:0];
				bla_pkg::REG_BLOCK_HEIGHT: bh_q  <= cfg_wdata[7:0];
				bla_pkg::REG_CELLS_ACROSS: ca_q  <= cfg_wdata[8:0];
				bla_pkg::REG_CELLS_DOWN:   cd_q  <= cfg_wdata[8:0];
				bla_pkg::REG_INVERT_RAMP:  inv_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q    <= '0;
			xin_q   <= '0;
			col_q   <= '0;
			line_q  <= '0;
			crow_q  <= '0;
			fover_q <= 1'b0;
		end else if (state_q == ST_RECALC && div_cnt_q == 5'd0) begin
			col_q <= div_quo_q[11:0];
			xin_q <= div_rem_q[7:0];
		end else if (in_acc) begin
			if (fover_c) begin
				px_q    <= px_c;
				xin_q   <= xin_c;
				col_q   <= col_c;
				line_q  <= line_c;
				crow_q  <= crow_c;
				fover_q <= fover_c;
			end else begin
				px_q    <= wrap ? 12'd0 : px_inc[11:0];
				xin_q   <= (wrap || xwrap) ? 8'd0 : xin_inc[7:0];
				col_q   <= wrap ? 12'd0 : (xwrap ? col_c + 12'd1 : col_c);
				line_q  <= wrap ? (lwrap ? 8'd0 : line_inc[7:0]) : line_c;
				crow_q  <= (wrap && lwrap) ? (cwrap ? 8'd0 : crow_inc[7:0]) : crow_c;
				fover_q <= wrap && lwrap && cwrap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc && active;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1     <= col_c;
			crow_s1    <= crow_c;
			first_s1   <= first_c;
			close_s1   <= close_c;
			fdone_s1   <= fdone_c;
			luma_s1    <= s_tdata;
			fwd_s1     <= fwd_c;
			vld_s1     <= vld_c;
			fwd_sum_s1 <= new_sum;
		end
	end

	// an invalid column reads as zero; frame start invalidates all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q <= '0;
		end else if (in_acc && fs) begin
			vbits_q <= '0;
		end else if (v_s1) begin
			vbits_q[col_s1[COL_W-1:0]] <= 1'b1;
		end
	end

	// sequencer: block average, gamma, ramp, and column re-derivation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (v_s1 && close_s1) begin
						div_cnt_q <= 5'(bla_pkg::BLK_STEPS);
						state_q   <= ST_DIV;
					end else if (bw_write) begin
						div_cnt_q <= 5'(bla_pkg::POS_STEPS);
						state_q   <= ST_RECALC;
					end
				end
				ST_DIV: begin
					if (div_cnt_q != 5'd0) begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end else begin
						state_q <= ST_GAM;
					end
				end
				ST_GAM: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RECALC: begin
					if (div_cnt_q != 5'd0) begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end else begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && v_s1 && close_s1) begin
			div_quo_q <= new_sum;
			div_rem_q <= '0;
			div_d_q   <= 16'(bw_e) * 16'(bh_e);
			col_d_q   <= col_s1[7:0];
			crow_d_q  <= crow_s1;
			fdone_d_q <= fdone_s1;
		end else if (state_q == ST_RUN && bw_write) begin
			div_quo_q <= {px_q, 12'd0};
			div_rem_q <= '0;
			div_d_q   <= {8'd0, (cfg_wdata[7:0] == 8'd0) ? 8'd1 : cfg_wdata[7:0]};
		end else if ((state_q == ST_DIV || state_q == ST_RECALC) && div_cnt_q != 5'd0) begin
			div_quo_q <= {div_quo_q[SW-2:0], ge};
			div_rem_q <= rem_next;
		end
		if (state_q == ST_GAM) begin
			gam_q <= bla_pkg::GAMMA_TABLE[avg] ^ {8{inv_q}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			glyph_q <= bla_pkg::ramp_glyph(gam_q);
			ocol_q  <= col_d_q;
			orow_q  <= crow_d_q;
			olast_q <= fdone_d_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, orow_q, ocol_q, glyph_q};
	assign m_tlast  = olast_q;

	a_close_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && v_s1 && close_s1) |=> (state_q == ST_DIV))
		else $error("closing pixel did not start the block divide");

	a_no_accept_while_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && close_s1) |-> !in_acc)
		else $error("pixel accepted while a block result is pending");

	a_frame_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fs) |=> ($countones(vbits_q) == 0))
		else $error("column valid bits not cleared at frame start");

	a_div_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_RECALC) |-> (div_cnt_q <= 5'(bla_pkg::BLK_STEPS)))
		else $error("divider step count out of range");

endmodule

>>> sv/bla_ram.sv
// bla_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module bla_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench of block_luma_to_ascii_glyph_core
// streams pixel frames under several block settings, predicts each emitted cell
// and compares it beat by beat; depends on bla_pkg and the core
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PIXELS = 360;
	localparam int IDLE_PAUSE = 40;

	typedef struct packed {
		logic [7:0] luma;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [6:0] glyph;
		logic [7:0] column;
		logic [7:0] row;
		logic       frame_done;
	} cell_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] luma
	logic [0:0]  s_tuser;   // [0] frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [6:0] glyph, [14:7] cell_column, [22:15] cell_row
	logic        m_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_wdata;

	block_luma_to_ascii_glyph_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pixel_t pixel_q[$];
	cell_t  cell_q[$];
	int     error_count = 0;
	int     cells_predicted = 0;
	int     cycle_count = 0;
	int     src_gap = 0;
	int     sink_gap = 0;
	bit     quiet_tail = 0;
	int     shade = 128;

	// predictor copy of registers and position state
	logic [11:0] cur_frame_width = bla_pkg::RST_FRAME_WIDTH;
	logic [7:0]  cur_block_width = bla_pkg::RST_BLOCK_WIDTH;
	logic [7:0]  cur_block_height = bla_pkg::RST_BLOCK_HEIGHT;
	logic [8:0]  cur_cells_across = bla_pkg::RST_CELLS_ACROSS;
	logic [8:0]  cur_cells_down = bla_pkg::RST_CELLS_DOWN;
	logic        cur_invert = bla_pkg::RST_INVERT_RAMP;
	logic [23:0] col_acc [256];
	int unsigned pos_x = 0;
	int unsigned line_in_cell = 0;
	int unsigned text_row = 0;
	bit          frame_finished = 0;
	logic [7:0]  gamma_lut [256];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gamma entry v counts k in 1..255 with (2k-1)^11 <= 2048 * 255^6 * v^5
	function automatic void build_gamma_lut();
		logic [127:0] limit;
		logic [127:0] odd_pow;
		logic [127:0] step_pow [255];
		int           v;
		int           k;
		int           n;
		for (k = 1; k <= 255; k++) begin
			odd_pow = 128'd1;
			repeat (11) odd_pow = odd_pow * 128'(2 * k - 1);
			step_pow[k - 1] = odd_pow;
		end
		for (v = 0; v < 256; v++) begin
			limit = 128'd2048;
			repeat (6) limit = limit * 128'd255;
			repeat (5) limit = limit * 128'(v);
			n = 0;
			for (k = 0; k < 255; k++) begin
				if (step_pow[k] <= limit) n++;
			end
			gamma_lut[v] = 8'(n);
		end
	endfunction

	task automatic predict_pixel(input logic [7:0] luma, input logic fs);
		int unsigned fw;
		int unsigned bw;
		int unsigned bh;
		int unsigned ca;
		int unsigned cd;
		int unsigned col;
		int unsigned xin;
		int unsigned avg;
		int unsigned level;
		int unsigned idx;
		cell_t       pred;
		fw = (cur_frame_width == 0) ? 1 : cur_frame_width;
		bw = (cur_block_width == 0) ? 1 : cur_block_width;
		bh = (cur_block_height == 0) ? 1 : cur_block_height;
		ca = (cur_cells_across == 0) ? 1 : cur_cells_across;
		cd = (cur_cells_down == 0) ? 1 : cur_cells_down;
		if (ca > 256) ca = 256;
		if (cd > 256) cd = 256;
		if (fs) begin
			foreach (col_acc[i]) col_acc[i] = '0;
			pos_x = 0;
			line_in_cell = 0;
			text_row = 0;
			frame_finished = 0;
		end
		if (frame_finished) return;
		col = pos_x / bw;
		if (col < ca && line_in_cell < bh) begin
			xin = pos_x % bw;
			if (line_in_cell == 0 && xin == 0) col_acc[col] = {16'd0, luma};
			else col_acc[col] = col_acc[col] + {16'd0, luma};
			if (line_in_cell == bh - 1 && xin == bw - 1) begin
				avg = col_acc[col] / (bw * bh);
				if (avg > 255) avg = 255;
				level = gamma_lut[avg];
				if (cur_invert) level = 255 - level;
				idx = bla_pkg::RAMP_LEN * level / 255;
				if (idx > bla_pkg::RAMP_LEN - 1) idx = bla_pkg::RAMP_LEN - 1;
				pred.glyph = bla_pkg::RAMP_CHARS[idx];
				pred.column = 8'(col);
				pred.row = 8'(text_row);
				pred.frame_done = (col == ca - 1 && text_row == cd - 1);
				cell_q.push_back(pred);
				cells_predicted++;
			end
		end
		pos_x++;
		if (pos_x >= fw) begin
			pos_x = 0;
			line_in_cell++;
			if (line_in_cell >= bh) begin
				line_in_cell = 0;
				text_row++;
				if (text_row >= cd) begin
					text_row = 0;
					frame_finished = 1;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			error_count++;
		end
	endtask

	// source side: one pixel beat per handshake, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				p = pixel_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= p.luma;
				s_tuser <= p.frame_start;
				if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 7);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side: stalls, result check, prediction of accepted pixels
	always @(posedge clk or negedge arst_n) begin
		cell_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 7);
			end
			if (m_tvalid && m_tready) begin
				if (cell_q.size() == 0) begin
					$error("cell beat col %0d row %0d with nothing pending",
						m_tdata[14:7], m_tdata[22:15]);
					error_count++;
				end else begin
					want = cell_q.pop_front();
					check_field("glyph", want.glyph, m_tdata[6:0]);
					check_field("cell_column", want.column, m_tdata[14:7]);
					check_field("cell_row", want.row, m_tdata[22:15]);
					check_field("frame_done", want.frame_done, m_tlast);
				end
			end
			if (s_tvalid && s_tready) predict_pixel(s_tdata, s_tuser[0]);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [7:0] next_luma();
		int val;
		if ($urandom_range(0, 7) == 0) shade = $urandom_range(0, 255);
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		val = shade + int'($urandom_range(0, 32)) - 16;
		if (val < 0) val = 0;
		if (val > 255) val = 255;
		return 8'(val);
	endfunction

	// mostly small sizes, sometimes zero, sometimes far out of the usual range
	function automatic int pick_size(input int common_hi, input int wide_hi);
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) return 0;
		if (r == 2) return $urandom_range(common_hi + 1, wide_hi);
		return $urandom_range(1, common_hi);
	endfunction

	task automatic push_pixel(input logic [7:0] luma, input logic fs);
		pixel_t p;
		p.luma = luma;
		p.frame_start = fs;
		pixel_q.push_back(p);
	endtask

	task automatic queue_run(input int count, input bit with_start, input bit noisy);
		int i;
		for (i = 0; i < count; i++) begin
			push_pixel(next_luma(), (i == 0 && with_start) ||
				(noisy && $urandom_range(0, 63) == 0));
		end
	endtask

	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_tvalid || cell_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 12'(val);
		case (idx)
			bla_pkg::REG_FRAME_WIDTH:  cur_frame_width = 12'(val);
			bla_pkg::REG_BLOCK_WIDTH:  cur_block_width = 8'(val);
			bla_pkg::REG_BLOCK_HEIGHT: cur_block_height = 8'(val);
			bla_pkg::REG_CELLS_ACROSS: cur_cells_across = 9'(val);
			bla_pkg::REG_CELLS_DOWN:   cur_cells_down = 9'(val);
			bla_pkg::REG_INVERT_RAMP:  cur_invert = 1'(val);
			default: ;
		endcase
	endtask

	// block width goes last since it starts the position re-derivation
	task automatic program_regs(input int fw, input int bw, input int bh,
		input int ca, input int cd, input int inv);
		wait_idle();
		repeat (IDLE_PAUSE) @(posedge clk);
		write_reg(bla_pkg::REG_FRAME_WIDTH, fw);
		write_reg(bla_pkg::REG_BLOCK_HEIGHT, bh);
		write_reg(bla_pkg::REG_CELLS_ACROSS, ca);
		write_reg(bla_pkg::REG_CELLS_DOWN, cd);
		write_reg(bla_pkg::REG_INVERT_RAMP, inv);
		write_reg(bla_pkg::REG_BLOCK_WIDTH, bw);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int random_pixels;
		int fw;
		int bh;
		int cd;
		int frame_len;
		int n;
		int frames;
		int f;
		random_pixels = 0;
		build_gamma_lut();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// 2x2 cells on a 4-wide frame: black, white, mid gray and a checker mix
		program_regs(4, 2, 2, 2, 2, 0);
		push_pixel(8'd0, 1'b1); push_pixel(8'd0, 1'b0);
		push_pixel(8'd255, 1'b0); push_pixel(8'd255, 1'b0);
		push_pixel(8'd0, 1'b0); push_pixel(8'd0, 1'b0);
		push_pixel(8'd255, 1'b0); push_pixel(8'd255, 1'b0);
		push_pixel(8'd128, 1'b0); push_pixel(8'd128, 1'b0);
		push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
		push_pixel(8'd128, 1'b0); push_pixel(8'd128, 1'b0);
		push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b0);
		// frame is over: ignored until the next frame start
		push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
		push_pixel(8'd255, 1'b1); push_pixel(8'd0, 1'b0);

		// all size registers zero, ramp inverted: each frame is one single-pixel cell
		program_regs(0, 0, 0, 0, 0, 1);
		push_pixel(8'd255, 1'b1); push_pixel(8'd7, 1'b0); push_pixel(8'd0, 1'b1);

		// widest frame and blocks, cell counts past saturation
		program_regs(4095, 255, 1, 511, 511, 1);
		queue_run(520, 1'b1, 1'b0);
		program_regs(1, 1, 255, 1, 1, 0);
		queue_run(258, 1'b1, 1'b0);
		program_regs(300, 1, 1, 256, 1, 0);
		queue_run(300, 1'b1, 1'b0);
		program_regs(1, 1, 1, 1, 256, 1);
		queue_run(258, 1'b1, 1'b0);

		while (random_pixels < RANDOM_PIXELS || cells_predicted < 48) begin
			quiet_tail = (random_pixels > RANDOM_PIXELS * 4 / 5);
			fw = pick_size(16, 4095);
			bh = pick_size(3, 255);
			cd = pick_size(4, 511);
			program_regs(fw, pick_size(4, 255), bh, pick_size(8, 511), cd,
				$urandom_range(0, 1));
			frame_len = (fw == 0 ? 1 : fw) * (bh == 0 ? 1 : bh) *
				(cd == 0 ? 1 : (cd > 256 ? 256 : cd));
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				n = frame_len + $urandom_range(0, 3);
				if (n > 150) n = $urandom_range(100, 150);
				// a run without frame start continues from the old position
				queue_run(n, f > 0 || $urandom_range(0, 6) != 0, 1'b1);
				random_pixels += (n < frame_len) ? n : frame_len;
			end
		end

		wait_idle();
		repeat (IDLE_PAUSE) @(posedge clk);
		if (error_count == 0 && cell_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
